// File: hdl/ahpo_pkg.sv
// shared types and constants for the horizontal push-out unit
`default_nettype none

package ahpo_pkg;

    // table and coordinate sizes
    localparam int MAX_BLOCKS  = 64;
    localparam int COORD_BITS  = 24;
    localparam int EXT_BITS    = COORD_BITS - 2;
    localparam int IDX_BITS    = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS    = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_BITS    = 7;
    localparam int BIDX_BITS   = 6;
    localparam int HIT_BITS    = 6;
    localparam int QUEUE_DEPTH = 2;

    // arithmetic widths
    localparam int SUM_W = COORD_BITS + 1;
    localparam int OV_W  = COORD_BITS + 2;
    localparam int NX_W  = COORD_BITS + 3;

    // request kinds on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // input tdata layout, lowest bit first
    localparam int S_BIDX_LO = 0;
    localparam int S_BL_LO   = S_BIDX_LO + BIDX_BITS;
    localparam int S_BT_LO   = S_BL_LO + COORD_BITS;
    localparam int S_BW_LO   = S_BT_LO + COORD_BITS;
    localparam int S_BH_LO   = S_BW_LO + EXT_BITS;
    localparam int S_EL_LO   = S_BH_LO + EXT_BITS;
    localparam int S_ET_LO   = S_EL_LO + COORD_BITS;
    localparam int S_EW_LO   = S_ET_LO + COORD_BITS;
    localparam int S_EH_LO   = S_EW_LO + EXT_BITS;
    localparam int S_EV_LO   = S_EH_LO + EXT_BITS;
    localparam int S_USED    = S_EV_LO + COORD_BITS;
    localparam int S_TDATA_W = ((S_USED + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int M_NL_LO   = 0;
    localparam int M_NV_LO   = M_NL_LO + COORD_BITS;
    localparam int M_PUSH_B  = M_NV_LO + COORD_BITS;
    localparam int M_DIR_B   = M_PUSH_B + 1;
    localparam int M_HIT_LO  = M_DIR_B + 1;
    localparam int M_USED    = M_HIT_LO + HIT_BITS;
    localparam int M_TDATA_W = ((M_USED + 7) / 8) * 8;

    // push directions
    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;

    // one stored block rectangle
    typedef struct packed {
        logic [EXT_BITS-1:0]          height;
        logic [EXT_BITS-1:0]          width;
        logic signed [COORD_BITS-1:0] top;
        logic signed [COORD_BITS-1:0] left;
    } blk_word_t;

    localparam int BLK_W = $bits(blk_word_t);

    // one queued query with its far edges worked out
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic signed [SUM_W-1:0]      er;
        logic signed [SUM_W-1:0]      eb;
        logic signed [COORD_BITS-1:0] hvel;
    } query_t;

    // scanner states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FIN
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/ahpo_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module ahpo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/ahpo_front.sv
// front end: takes requests, stores blocks, turns queries into queue entries
`default_nettype none

module ahpo_front (
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [ahpo_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tuser,
    input  wire logic                                 q_full,
    input  wire logic                                 q_empty,
    input  wire logic                                 back_busy,
    output logic                                      q_push,
    output ahpo_pkg::query_t                          q_desc,
    output logic                                      wr_en,
    output logic [ahpo_pkg::IDX_BITS-1:0]             wr_addr,
    output ahpo_pkg::blk_word_t                       wr_data
);

    logic [ahpo_pkg::BIDX_BITS-1:0]         bidx;
    logic signed [ahpo_pkg::COORD_BITS-1:0] ex;
    logic signed [ahpo_pkg::COORD_BITS-1:0] ey;
    logic [ahpo_pkg::EXT_BITS-1:0]          ew;
    logic [ahpo_pkg::EXT_BITS-1:0]          eh;
    logic                                   is_query;
    logic                                   accept;

    // field extraction
    assign bidx = s_tdata[ahpo_pkg::S_BIDX_LO +: ahpo_pkg::BIDX_BITS];
    assign ex   = signed'(s_tdata[ahpo_pkg::S_EL_LO +: ahpo_pkg::COORD_BITS]);
    assign ey   = signed'(s_tdata[ahpo_pkg::S_ET_LO +: ahpo_pkg::COORD_BITS]);
    assign ew   = s_tdata[ahpo_pkg::S_EW_LO +: ahpo_pkg::EXT_BITS];
    assign eh   = s_tdata[ahpo_pkg::S_EH_LO +: ahpo_pkg::EXT_BITS];

    // queries wait for queue room; writes wait until no query is pending
    assign is_query = (s_tuser == ahpo_pkg::REQ_QUERY);
    assign s_tready = is_query ? !q_full : (q_empty && !back_busy);
    assign accept   = s_tvalid && s_tready;

    // block store, out-of-range indexes dropped
    assign wr_en   = accept && !is_query && (int'(bidx) < ahpo_pkg::MAX_BLOCKS);
    assign wr_addr = ahpo_pkg::IDX_BITS'(bidx);
    assign wr_data.left   = signed'(s_tdata[ahpo_pkg::S_BL_LO +: ahpo_pkg::COORD_BITS]);
    assign wr_data.top    = signed'(s_tdata[ahpo_pkg::S_BT_LO +: ahpo_pkg::COORD_BITS]);
    assign wr_data.width  = s_tdata[ahpo_pkg::S_BW_LO +: ahpo_pkg::EXT_BITS];
    assign wr_data.height = s_tdata[ahpo_pkg::S_BH_LO +: ahpo_pkg::EXT_BITS];

    // query entry with right and bottom edges
    assign q_push    = accept && is_query;
    assign q_desc.ex = ex;
    assign q_desc.ey = ey;
    assign q_desc.er = ahpo_pkg::SUM_W'(ex)
                     + ahpo_pkg::SUM_W'({1'b0, ew});
    assign q_desc.eb = ahpo_pkg::SUM_W'(ey)
                     + ahpo_pkg::SUM_W'({1'b0, eh});
    assign q_desc.hvel = signed'(s_tdata[ahpo_pkg::S_EV_LO +: ahpo_pkg::COORD_BITS]);

endmodule

`default_nettype wire

// File: hdl/ahpo_query_queue.sv
// short fifo of pending queries between front end and scanner
`default_nettype none

module ahpo_query_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire ahpo_pkg::query_t push_data,
    input  wire logic             pop,
    output ahpo_pkg::query_t      head,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_BITS = (ahpo_pkg::QUEUE_DEPTH > 1) ? $clog2(ahpo_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_BITS = $clog2(ahpo_pkg::QUEUE_DEPTH + 1);

    ahpo_pkg::query_t       slot_reg [ahpo_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;

    assign full  = (int'(fill_reg) == ahpo_pkg::QUEUE_DEPTH);
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == ahpo_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == ahpo_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_BITS'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ahpo_back.sv
// scanner: walks the block table for one query and builds the result
`default_nettype none

module ahpo_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ahpo_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                                q_empty,
    input  wire ahpo_pkg::query_t                    q_head,
    output logic                                     q_pop,
    output logic                                     back_busy,
    output logic                                     rd_en,
    output logic [ahpo_pkg::IDX_BITS-1:0]            rd_addr,
    input  wire ahpo_pkg::blk_word_t                 rd_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ahpo_pkg::M_TDATA_W-1:0]           m_tdata
);

    localparam int SW = ahpo_pkg::SUM_W;
    localparam int OW = ahpo_pkg::OV_W;
    localparam int NW = ahpo_pkg::NX_W;
    localparam int CW = ahpo_pkg::COORD_BITS;
    localparam int IW = ahpo_pkg::IDX_BITS;
    localparam int KW = ahpo_pkg::CNT_BITS;
    localparam logic signed [NW-1:0] SAT_HI = NW'((2 ** (CW - 1)) - 1);
    localparam logic signed [NW-1:0] SAT_LO = -SAT_HI - NW'(1);

    ahpo_pkg::back_state_t state_reg, state_next;

    logic [ahpo_pkg::CFG_BITS-1:0] active_reg;
    ahpo_pkg::query_t              qry_reg;
    logic [KW-1:0]                 cnt_reg;
    logic [KW-1:0]                 idx_reg, idx_next;

    // pipeline valids and indexes
    logic          p0_v_reg, sa_v_reg, sb_v_reg;
    logic [IW-1:0] p0_idx_reg, sa_idx_reg, sb_idx_reg;

    // stage a: far edges and near-side penetrations
    logic signed [SW-1:0] sa_br_reg, sa_bb_reg;
    logic signed [OW-1:0] sa_ovl_reg, sa_ovt_reg;
    // stage b: all four penetrations
    logic signed [OW-1:0] sb_ovl_reg, sb_ovr_reg, sb_ovt_reg, sb_ovb_reg;

    // latched hit
    logic                 found_reg;
    logic                 dir_reg;
    logic signed [OW-1:0] hov_reg;
    logic [IW-1:0]        hit_idx_reg;

    logic                  m_tvalid_reg;
    logic [ahpo_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [ahpo_pkg::M_TDATA_W-1:0] m_tdata_next;

    // control
    logic                 issue;
    logic                 start;
    logic                 load_out;
    logic                 drained;
    logic                 hit_now;
    logic                 go_left;
    logic signed [OW-1:0] hov, vov;
    logic                 overlap;
    logic signed [SW-1:0] bl_w, bt_w;
    logic [KW-1:0]        cnt_clamped;
    logic signed [NW-1:0] nx;
    logic signed [CW-1:0] nx_sat;

    // config register: the user must write it only while idle; the block does not enforce it
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cfg_valid) begin
            active_reg <= cfg_data;
        end
    end

    assign cnt_clamped = (int'(active_reg) > ahpo_pkg::MAX_BLOCKS)
                       ? KW'(ahpo_pkg::MAX_BLOCKS) : KW'(active_reg);

    // stage c decision on registered penetrations
    assign overlap = !sb_ovl_reg[OW-1] && (sb_ovl_reg != '0)
                  && !sb_ovr_reg[OW-1] && (sb_ovr_reg != '0)
                  && !sb_ovt_reg[OW-1] && (sb_ovt_reg != '0)
                  && !sb_ovb_reg[OW-1] && (sb_ovb_reg != '0);
    assign go_left = sb_ovl_reg < sb_ovr_reg;
    assign hov     = go_left ? sb_ovl_reg : sb_ovr_reg;
    assign vov     = (sb_ovt_reg < sb_ovb_reg) ? sb_ovt_reg : sb_ovb_reg;
    assign hit_now = (state_reg == ahpo_pkg::BK_SCAN) && sb_v_reg && overlap && (hov < vov);

    assign drained = (idx_reg >= cnt_reg) && !p0_v_reg && !sa_v_reg && !sb_v_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ahpo_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    state_next = ahpo_pkg::BK_SCAN;
                end
            end
            ahpo_pkg::BK_SCAN: begin
                if (hit_now || drained) begin
                    state_next = ahpo_pkg::BK_FIN;
                end
            end
            ahpo_pkg::BK_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ahpo_pkg::BK_IDLE;
                end
            end
            default: state_next = ahpo_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        start     = 1'b0;
        issue     = 1'b0;
        load_out  = 1'b0;
        back_busy = 1'b0;
        unique case (state_reg)
            ahpo_pkg::BK_IDLE: begin
                start = !q_empty;
            end
            ahpo_pkg::BK_SCAN: begin
                back_busy = 1'b1;
                issue     = (idx_reg < cnt_reg) && !hit_now;
            end
            ahpo_pkg::BK_FIN: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                start = 1'b0;
            end
        endcase
    end

    assign q_pop   = start;
    assign rd_en   = issue;
    assign rd_addr = idx_reg[IW-1:0];
    assign idx_next = issue ? idx_reg + KW'(1) : idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ahpo_pkg::BK_IDLE;
            p0_v_reg  <= 1'b0;
            sa_v_reg  <= 1'b0;
            sb_v_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p0_v_reg  <= issue;
            sa_v_reg  <= p0_v_reg && !hit_now;
            sb_v_reg  <= sa_v_reg && !hit_now;
            if (start) begin
                found_reg <= 1'b0;
            end else if (hit_now) begin
                found_reg <= 1'b1;
            end
        end
    end

    // query load and scan index
    always_ff @(posedge aclk) begin
        if (start) begin
            qry_reg <= q_head;
            cnt_reg <= cnt_clamped;
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    // stage a from ram data
    assign bl_w = SW'(rd_data.left);
    assign bt_w = SW'(rd_data.top);
    always_ff @(posedge aclk) begin
        p0_idx_reg <= idx_reg[IW-1:0];
        sa_idx_reg <= p0_idx_reg;
        sb_idx_reg <= sa_idx_reg;
        sa_br_reg  <= bl_w + SW'({1'b0, rd_data.width});
        sa_bb_reg  <= bt_w + SW'({1'b0, rd_data.height});
        sa_ovl_reg <= OW'(qry_reg.er) - OW'(bl_w);
        sa_ovt_reg <= OW'(qry_reg.eb) - OW'(bt_w);
    end

    // stage b: far-side penetrations
    always_ff @(posedge aclk) begin
        sb_ovl_reg <= sa_ovl_reg;
        sb_ovt_reg <= sa_ovt_reg;
        sb_ovr_reg <= OW'(sa_br_reg) - OW'(qry_reg.ex);
        sb_ovb_reg <= OW'(sa_bb_reg) - OW'(qry_reg.ey);
    end

    // first hit wins
    always_ff @(posedge aclk) begin
        if (hit_now) begin
            dir_reg     <= go_left ? ahpo_pkg::DIR_LEFT : ahpo_pkg::DIR_RIGHT;
            hov_reg     <= hov;
            hit_idx_reg <= sb_idx_reg;
        end
    end

    // pushed position with saturation
    assign nx = (dir_reg == ahpo_pkg::DIR_LEFT)
              ? NW'(qry_reg.ex) - NW'(hov_reg)
              : NW'(qry_reg.ex) + NW'(hov_reg);
    always_comb begin
        priority if (nx > SAT_HI) begin
            nx_sat = SAT_HI[CW-1:0];
        end else if (nx < SAT_LO) begin
            nx_sat = SAT_LO[CW-1:0];
        end else begin
            nx_sat = nx[CW-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result word
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[ahpo_pkg::M_NL_LO +: CW] = found_reg ? nx_sat : qry_reg.ex;
        m_tdata_next[ahpo_pkg::M_NV_LO +: CW] = found_reg ? '0 : qry_reg.hvel;
        m_tdata_next[ahpo_pkg::M_PUSH_B]      = found_reg;
        m_tdata_next[ahpo_pkg::M_DIR_B]       = found_reg && dir_reg;
        m_tdata_next[ahpo_pkg::M_HIT_LO +: ahpo_pkg::HIT_BITS] =
            found_reg ? ahpo_pkg::HIT_BITS'(hit_idx_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: hdl/aabb_horizontal_push_out_unit.sv
// top level of the horizontal push-out unit
//
// Input stream (s_): s_tuser selects the request kind. A write request
// stores one block rectangle at block_index and gives no result; it is
// taken only while no query is queued or being scanned.
// A query request carries an entity box and its horizontal velocity and
// gives exactly one result on the m_ stream. Up to two queries queue up
// in front of the scanner while it works or while a result waits.
// The scanner reads one table entry per cycle from the block ram and
// handles one query at a time, scanning N entries, N being the scanned
// count min(active_blocks, 64); a hit on entry k ends the scan early.
// The cfg_ channel loads active_blocks; write it only while idle.
// Reset (aresetn low, synchronous) empties the queue and output register
// and clears active_blocks; the block table itself is not cleared.
// When m_tready is low the result holds, the scanner stops after its
// current query, and the front end keeps queuing until the queue is full.
`default_nettype none

module aabb_horizontal_push_out_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration: active_blocks
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ahpo_pkg::CFG_BITS-1:0]       cfg_data,
    // input requests
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // block_index, block_left, block_top, block_width, block_height,
    // entity_left, entity_top, entity_width, entity_height, entity_hvel, zero pad
    input  wire logic [ahpo_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type
    input  wire logic                                s_tuser,
    // results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // new_left, new_hvel, pushed, push_dir, hit_index
    output logic [ahpo_pkg::M_TDATA_W-1:0]           m_tdata
);

    ahpo_pkg::query_t             push_desc;
    ahpo_pkg::query_t             head_desc;
    ahpo_pkg::blk_word_t          wr_word;
    ahpo_pkg::blk_word_t          rd_word;
    logic                         q_push, q_pop, q_full, q_empty;
    logic                         back_busy;
    logic                         wr_en, rd_en;
    logic [ahpo_pkg::IDX_BITS-1:0] wr_addr, rd_addr;
    logic [ahpo_pkg::BLK_W-1:0]   rd_raw;

    // request intake
    ahpo_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .back_busy (back_busy),
        .q_push    (q_push),
        .q_desc    (push_desc),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_word)
    );

    // pending queries
    ahpo_query_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_desc),
        .pop       (q_pop),
        .head      (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    // block table
    ahpo_ram #(
        .WIDTH (ahpo_pkg::BLK_W),
        .DEPTH (ahpo_pkg::MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_word = rd_raw;

    // table scan and result
    ahpo_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (head_desc),
        .q_pop     (q_pop),
        .back_busy (back_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_word),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/ahpo_checker.sv
// port-level checks for the horizontal push-out unit, bound to the top level
`default_nettype none

module ahpo_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                cfg_valid,
    input wire logic                                cfg_ready,
    input wire logic [ahpo_pkg::CFG_BITS-1:0]       cfg_data,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [ahpo_pkg::S_TDATA_W-1:0]      s_tdata,
    input wire logic                                s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [ahpo_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic pushed;
    logic dir;
    logic [ahpo_pkg::COORD_BITS-1:0] hvel;
    logic [ahpo_pkg::HIT_BITS-1:0]   hit;

    assign pushed = m_tdata[ahpo_pkg::M_PUSH_B];
    assign dir    = m_tdata[ahpo_pkg::M_DIR_B];
    assign hvel   = m_tdata[ahpo_pkg::M_NV_LO +: ahpo_pkg::COORD_BITS];
    assign hit    = m_tdata[ahpo_pkg::M_HIT_LO +: ahpo_pkg::HIT_BITS];

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a push always stops the entity
    a_push_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && pushed |-> hvel == '0)
        else $error("pushed result with nonzero velocity");

    // no push leaves direction and index at zero
    a_nopush_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !pushed |-> !dir && hit == '0)
        else $error("unpushed result with direction or index set");

endmodule

bind aabb_horizontal_push_out_unit ahpo_checker u_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// testbench for the horizontal push-out unit: a directed request table, then random block scenes
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 170;
    localparam int SCENE_SPAN     = 'h10000;
    localparam int SCENE_SIZE     = 'h2000;

    localparam longint COORD_MAX = (longint'(1) << (ahpo_pkg::COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // one request as it goes onto the input stream
    typedef struct {
        logic                                   kind;
        logic [ahpo_pkg::BIDX_BITS-1:0]         index;
        ahpo_pkg::blk_word_t                    blk;
        logic signed [ahpo_pkg::COORD_BITS-1:0] ent_left;
        logic signed [ahpo_pkg::COORD_BITS-1:0] ent_top;
        logic [ahpo_pkg::EXT_BITS-1:0]          ent_width;
        logic [ahpo_pkg::EXT_BITS-1:0]          ent_height;
        logic signed [ahpo_pkg::COORD_BITS-1:0] ent_hvel;
    } request_t;

    // one push-out result
    typedef struct {
        logic [ahpo_pkg::COORD_BITS-1:0] new_left;
        logic [ahpo_pkg::COORD_BITS-1:0] new_hvel;
        logic                            pushed;
        logic                            dir;
        logic [ahpo_pkg::HIT_BITS-1:0]   hit;
    } push_result_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t    kind;
        request_t     req;
        bit           typed;
        push_result_t want;
        int           setting;
    } directed_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ahpo_pkg::CFG_BITS-1:0]    cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    // block_index, block_left, block_top, block_width, block_height,
    // entity_left, entity_top, entity_width, entity_height, entity_hvel, zero pad
    logic [ahpo_pkg::S_TDATA_W-1:0]   s_tdata;
    // req_type
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    // new_left, new_hvel, pushed, push_dir, hit_index
    logic [ahpo_pkg::M_TDATA_W-1:0]   m_tdata;

    // predictor state
    ahpo_pkg::blk_word_t    block_table [ahpo_pkg::MAX_BLOCKS];
    int                     active_count;
    push_result_t           pending_results [$];
    directed_row_t          directed_rows [$];

    int                     mismatch_count = 0;
    int                     stall_cycles = 0;
    bit                     calm;
    logic signed [ahpo_pkg::COORD_BITS-1:0] scene_x;
    logic signed [ahpo_pkg::COORD_BITS-1:0] scene_y;

    aabb_horizontal_push_out_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // scan the block table the way the unit does and give the push-out
    function automatic push_result_t resolve_push(input request_t r);
        push_result_t res;
        longint ex, ey, er, eb, bl, bt, br, bb;
        longint ov_l, ov_r, ov_t, ov_b, hov, vov, nx;
        int scan;
        bit go_left;
        ex = longint'(r.ent_left);
        ey = longint'(r.ent_top);
        er = ex + longint'(r.ent_width);
        eb = ey + longint'(r.ent_height);
        res = '{new_left: r.ent_left, new_hvel: r.ent_hvel, pushed: 1'b0,
                dir: ahpo_pkg::DIR_LEFT, hit: '0};
        scan = (active_count > ahpo_pkg::MAX_BLOCKS) ? ahpo_pkg::MAX_BLOCKS : active_count;
        for (int i = 0; i < scan; i++) begin
            bl = longint'($signed(block_table[i].left));
            bt = longint'($signed(block_table[i].top));
            br = bl + longint'(block_table[i].width);
            bb = bt + longint'(block_table[i].height);
            // only a strict overlap counts
            if (er <= bl || br <= ex || eb <= bt || bb <= ey) continue;
            ov_l = er - bl;
            ov_r = br - ex;
            ov_t = eb - bt;
            ov_b = bb - ey;
            go_left = ov_l < ov_r;
            hov = go_left ? ov_l : ov_r;
            vov = (ov_t < ov_b) ? ov_t : ov_b;
            if (hov < vov) begin
                nx = go_left ? ex - ov_l : ex + ov_r;
                if (nx > COORD_MAX) nx = COORD_MAX;
                else if (nx < COORD_MIN) nx = COORD_MIN;
                res.new_left = nx[ahpo_pkg::COORD_BITS-1:0];
                res.new_hvel = '0;
                res.pushed   = 1'b1;
                res.dir      = go_left ? ahpo_pkg::DIR_LEFT : ahpo_pkg::DIR_RIGHT;
                res.hit      = ahpo_pkg::HIT_BITS'(i);
                break;
            end
        end
        return res;
    endfunction

    function automatic logic [ahpo_pkg::S_TDATA_W-1:0] pack_request(input request_t r);
        logic [ahpo_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[ahpo_pkg::S_BIDX_LO +: ahpo_pkg::BIDX_BITS] = r.index;
        d[ahpo_pkg::S_BL_LO +: ahpo_pkg::COORD_BITS]  = r.blk.left;
        d[ahpo_pkg::S_BT_LO +: ahpo_pkg::COORD_BITS]  = r.blk.top;
        d[ahpo_pkg::S_BW_LO +: ahpo_pkg::EXT_BITS]    = r.blk.width;
        d[ahpo_pkg::S_BH_LO +: ahpo_pkg::EXT_BITS]    = r.blk.height;
        d[ahpo_pkg::S_EL_LO +: ahpo_pkg::COORD_BITS]  = r.ent_left;
        d[ahpo_pkg::S_ET_LO +: ahpo_pkg::COORD_BITS]  = r.ent_top;
        d[ahpo_pkg::S_EW_LO +: ahpo_pkg::EXT_BITS]    = r.ent_width;
        d[ahpo_pkg::S_EH_LO +: ahpo_pkg::EXT_BITS]    = r.ent_height;
        d[ahpo_pkg::S_EV_LO +: ahpo_pkg::COORD_BITS]  = r.ent_hvel;
        return d;
    endfunction

    // directed table builders
    function automatic directed_row_t blank_row(input row_kind_t kind);
        directed_row_t row;
        row.kind    = kind;
        row.req     = '{default: '0};
        row.typed   = 1'b0;
        row.want    = '{default: '0};
        row.setting = 0;
        return row;
    endfunction

    function automatic void add_write(input int idx, input int l, input int t,
                                      input int w, input int h);
        directed_row_t row;
        row = blank_row(ROW_REQUEST);
        row.req.kind       = ahpo_pkg::REQ_WRITE;
        row.req.index      = ahpo_pkg::BIDX_BITS'(idx);
        row.req.blk.left   = ahpo_pkg::COORD_BITS'(l);
        row.req.blk.top    = ahpo_pkg::COORD_BITS'(t);
        row.req.blk.width  = ahpo_pkg::EXT_BITS'(w);
        row.req.blk.height = ahpo_pkg::EXT_BITS'(h);
        directed_rows.push_back(row);
    endfunction

    function automatic directed_row_t query_row(input int l, input int t, input int w,
                                                input int h, input int v);
        directed_row_t row;
        row = blank_row(ROW_REQUEST);
        row.req.kind       = ahpo_pkg::REQ_QUERY;
        row.req.ent_left   = ahpo_pkg::COORD_BITS'(l);
        row.req.ent_top    = ahpo_pkg::COORD_BITS'(t);
        row.req.ent_width  = ahpo_pkg::EXT_BITS'(w);
        row.req.ent_height = ahpo_pkg::EXT_BITS'(h);
        row.req.ent_hvel   = ahpo_pkg::COORD_BITS'(v);
        return row;
    endfunction

    function automatic void add_query(input int l, input int t, input int w,
                                      input int h, input int v);
        directed_rows.push_back(query_row(l, t, w, h, v));
    endfunction

    function automatic void add_typed(input int l, input int t, input int w, input int h,
                                      input int v, input int nl, input int nv,
                                      input logic pu, input logic dr, input int hit);
        directed_row_t row;
        row = query_row(l, t, w, h, v);
        row.typed = 1'b1;
        row.want  = '{new_left: ahpo_pkg::COORD_BITS'(nl),
                      new_hvel: ahpo_pkg::COORD_BITS'(nv),
                      pushed: pu, dir: dr, hit: ahpo_pkg::HIT_BITS'(hit)};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_config(input int value);
        directed_row_t row;
        row = blank_row(ROW_CONFIG);
        row.setting = value;
        directed_rows.push_back(row);
    endfunction

    // random request generators
    function automatic request_t noise_request();
        request_t r;
        r.kind       = 1'($urandom);
        r.index      = ahpo_pkg::BIDX_BITS'($urandom);
        r.blk        = ahpo_pkg::BLK_W'({$urandom, $urandom, $urandom});
        r.ent_left   = ahpo_pkg::COORD_BITS'($urandom);
        r.ent_top    = ahpo_pkg::COORD_BITS'($urandom);
        r.ent_width  = ahpo_pkg::EXT_BITS'($urandom);
        r.ent_height = ahpo_pkg::EXT_BITS'($urandom);
        r.ent_hvel   = ahpo_pkg::COORD_BITS'($urandom);
        return r;
    endfunction

    function automatic request_t scene_block(input int idx);
        request_t r;
        r = noise_request();
        r.kind           = ahpo_pkg::REQ_WRITE;
        r.index          = ahpo_pkg::BIDX_BITS'(idx);
        r.blk.left       = ahpo_pkg::COORD_BITS'(int'(scene_x)
                         + int'($urandom_range(0, SCENE_SPAN)));
        r.blk.top        = ahpo_pkg::COORD_BITS'(int'(scene_y)
                         + int'($urandom_range(0, SCENE_SPAN)));
        r.blk.width      = ahpo_pkg::EXT_BITS'(($urandom_range(0, 9) == 0)
                         ? 0 : $urandom_range(1, SCENE_SIZE));
        r.blk.height     = ahpo_pkg::EXT_BITS'(($urandom_range(0, 9) == 0)
                         ? 0 : $urandom_range(1, SCENE_SIZE));
        return r;
    endfunction

    // entity box dropped near one of the scanned blocks, or near any block when none is scanned
    function automatic request_t scene_query();
        request_t r;
        ahpo_pkg::blk_word_t b;
        int lim, ew, eh;
        r = noise_request();
        lim = (active_count == 0) ? ahpo_pkg::MAX_BLOCKS
            : (active_count > ahpo_pkg::MAX_BLOCKS) ? ahpo_pkg::MAX_BLOCKS : active_count;
        b = block_table[$urandom_range(0, lim - 1)];
        ew = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, SCENE_SIZE));
        eh = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, SCENE_SIZE));
        r.kind       = ahpo_pkg::REQ_QUERY;
        r.ent_width  = ahpo_pkg::EXT_BITS'(ew);
        r.ent_height = ahpo_pkg::EXT_BITS'(eh);
        r.ent_left   = ahpo_pkg::COORD_BITS'(int'($signed(b.left)) - ew
                     + int'($urandom_range(0, int'(b.width) + ew)));
        r.ent_top    = ahpo_pkg::COORD_BITS'(int'($signed(b.top)) - eh
                     + int'($urandom_range(0, int'(b.height) + eh)));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // send one request, with random gaps ahead of it unless calm; called at a falling edge
    task automatic send_request(input request_t r, input bit typed,
                                input push_result_t want);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        s_tuser  <= r.kind;
        do @(posedge aclk); while (!s_tready);
        if (r.kind == ahpo_pkg::REQ_WRITE) begin
            block_table[r.index] = r.blk;
        end else begin
            pending_results.push_back(typed ? want : resolve_push(r));
        end
        @(negedge aclk);
    endtask

    // hold off until every result is back and the scanner has gone quiet
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_config(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= ahpo_pkg::CFG_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
        active_count = value & ((1 << ahpo_pkg::CFG_BITS) - 1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        push_result_t oldest;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 64'(m_tdata), 64'(0));
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata[ahpo_pkg::M_NL_LO +: ahpo_pkg::COORD_BITS] !== oldest.new_left)
                    report_mismatch("new_left",
                                    64'(m_tdata[ahpo_pkg::M_NL_LO +: ahpo_pkg::COORD_BITS]),
                                    64'(oldest.new_left));
                if (m_tdata[ahpo_pkg::M_NV_LO +: ahpo_pkg::COORD_BITS] !== oldest.new_hvel)
                    report_mismatch("new_hvel",
                                    64'(m_tdata[ahpo_pkg::M_NV_LO +: ahpo_pkg::COORD_BITS]),
                                    64'(oldest.new_hvel));
                if (m_tdata[ahpo_pkg::M_PUSH_B] !== oldest.pushed)
                    report_mismatch("pushed", 64'(m_tdata[ahpo_pkg::M_PUSH_B]),
                                    64'(oldest.pushed));
                if (m_tdata[ahpo_pkg::M_DIR_B] !== oldest.dir)
                    report_mismatch("push_dir", 64'(m_tdata[ahpo_pkg::M_DIR_B]),
                                    64'(oldest.dir));
                if (m_tdata[ahpo_pkg::M_HIT_LO +: ahpo_pkg::HIT_BITS] !== oldest.hit)
                    report_mismatch("hit_index",
                                    64'(m_tdata[ahpo_pkg::M_HIT_LO +: ahpo_pkg::HIT_BITS]),
                                    64'(oldest.hit));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("aabb_horizontal_push_out_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        request_t     req;
        push_result_t none;
        int           phase_setting [PHASE_COUNT];
        int           choice;

        none = '{default: '0};
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ahpo_pkg::REQ_WRITE;
        calm      = 1'b0;
        active_count = 0;

        // nothing is scanned straight after reset: the box passes through
        add_typed('h7FFFFF, -'h800000, 'h3FFFFF, 0, -'h800000,
                  'h7FFFFF, -'h800000, 1'b0, ahpo_pkg::DIR_LEFT, 0);
        add_typed(-'h800000, 'h7FFFFF, 0, 'h3FFFFF, 'h7FFFFF,
                  -'h800000, 'h7FFFFF, 1'b0, ahpo_pkg::DIR_LEFT, 0);
        // huge blocks at both ends of the range, two plain ones, and the top index
        add_write(0, 'h7FFF00, 0, 'h3FFFFF, 'h3FFFFF);
        add_write(1, -'h800000, 0, 'h3FFFFF, 'h3FFFFF);
        add_write(2, 0, 0, 'h1000, 'h1000);
        add_write(3, 0, 0, 'h1000, 'h1000);
        add_write(ahpo_pkg::MAX_BLOCKS - 1, 'h7FFFFF, 'h7FFFFF, 0, 0);
        add_config(4);
        // push past the top and the bottom of the range saturates
        add_typed('h7FFFFF, 0, 'h3FFFFF, 'h3FFFFF, 'h123456,
                  'h7FFFFF, 0, 1'b1, ahpo_pkg::DIR_RIGHT, 0);
        add_typed(-'h800000, 0, 'h100, 'h3FFFFF, -5,
                  -'h800000, 0, 1'b1, ahpo_pkg::DIR_LEFT, 1);
        // push left, push right, equal sides, vertical wins, touching, zero width
        add_query(-'h800, 'h400, 'hA00, 'h400, 'h300);
        add_query('hE00, 'h400, 'h800, 'h400, -'h300);
        add_query('h400, -'h800, 'h800, 'h2000, 'h100);
        add_query('h100, -'h100, 'hE00, 'h200, 'h55);
        add_query(-'h800, 'h400, 'h800, 'h400, 7);
        add_query('h200, 'h800, 0, 'h100, 1);
        // fewer scanned entries hide the later blocks
        add_config(1);
        add_query(-'h800, 'h400, 'hA00, 'h400, 'h300);
        add_config(2);
        add_query(-'h800000, 0, 'h100, 'h3FFFFF, -5);
        add_query(-'h800, 'h400, 'hA00, 'h400, 'h300);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                settle_idle();
                write_config(directed_rows[i].setting);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].want);
            end
        end

        // random scenes, each under its own scan count
        phase_setting = '{127, 64, 1, 0, 65, 0};
        phase_setting[PHASE_COUNT - 1] = int'($urandom_range(2, ahpo_pkg::MAX_BLOCKS - 1));
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle_idle();
            calm = (p == 1);
            write_config(phase_setting[p]);
            scene_x = ahpo_pkg::COORD_BITS'($urandom);
            scene_y = ahpo_pkg::COORD_BITS'($urandom);
            if (p == 0) scene_x = ahpo_pkg::COORD_BITS'('h7FC000);
            if (p == 4) scene_x = ahpo_pkg::COORD_BITS'(-'h800000);
            // fill the whole table before any query reads it
            for (int k = 0; k < ahpo_pkg::MAX_BLOCKS; k++) begin
                send_request(scene_block(k), 1'b0, none);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) settle_idle();
                choice = $urandom_range(0, 99);
                if (choice < 15) req = noise_request();
                else if (choice < 40)
                    req = scene_block($urandom_range(0, ahpo_pkg::MAX_BLOCKS - 1));
                else req = scene_query();
                send_request(req, 1'b0, none);
            end
        end
        calm = 1'b0;

        settle_idle();
        if (mismatch_count == 0) begin
            $display("aabb_horizontal_push_out_unit test passed");
        end else begin
            $display("aabb_horizontal_push_out_unit test failed");
        end
        $finish;
    end

endmodule
